// File: hdl/mus_pkg.sv
// shared types and constants for the modified utf-8 byte sanitizer
// no dependencies; used by mus_skid, mus_decode and the top level
`timescale 1ns / 1ps
`default_nettype none

package mus_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned CNT_W    = 2;
  // skid beat: byte in the low bits, end flag on top
  localparam int unsigned IN_W     = BYTE_W + 1;

  localparam logic [BYTE_W-1:0] REPL_RESET = 8'h3F;
  localparam logic [1:0]        CONT_TAG   = 2'b10;
  localparam logic [3:0]        THREE_HI   = 4'hE;
  localparam logic [3:0]        ILLEGAL_HI = 4'hF;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t            lead;
    byte_t            cont;
    logic [CNT_W-1:0] cnt;
    logic             three;
  } hold_t;

  typedef struct packed {
    byte_t [MAX_RES-1:0] bytes;
    logic  [CNT_W-1:0]   cnt;
    hold_t               hold;
  } step_t;

endpackage

`default_nettype wire

// File: hdl/mus_skid.sv
// two-entry skid buffer with a registered ready towards the source
// depends on mus_pkg for the default beat width
`timescale 1ns / 1ps
`default_nettype none

module mus_skid #(
  parameter int unsigned WIDTH = mus_pkg::IN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s_valid,
  output logic                  s_ready,
  input  wire logic [WIDTH-1:0] s_data,
  output logic                  m_valid,
  input  wire logic             m_ready,
  output logic [WIDTH-1:0]      m_data
);

  logic             val_r;
  logic [WIDTH-1:0] dat_r;
  logic             skid_val_r;
  logic [WIDTH-1:0] skid_dat_r;
  logic             s_fire;
  logic             pop;

  assign s_ready = ~skid_val_r;
  assign s_fire  = s_valid & s_ready;
  assign pop     = val_r & m_ready;
  assign m_valid = val_r;
  assign m_data  = dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r      <= 1'b0;
      skid_val_r <= 1'b0;
    end else if (!val_r || pop) begin
      if (skid_val_r) begin
        val_r      <= 1'b1;
        skid_val_r <= 1'b0;
      end else begin
        val_r <= s_fire;
      end
    end else if (s_fire) begin
      skid_val_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!val_r || pop) begin
      dat_r <= skid_val_r ? skid_dat_r : s_data;
    end else if (s_fire) begin
      skid_dat_r <= s_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mus_decode.sv
// one byte step of the repair: results and next held state, combinational
// depends on mus_pkg for hold_t and step_t
`timescale 1ns / 1ps
`default_nettype none

module mus_decode (
  input  wire mus_pkg::hold_t hold,
  input  wire mus_pkg::byte_t in_byte,
  input  wire logic           string_end,
  input  wire mus_pkg::byte_t repl,
  output mus_pkg::step_t      step
);

  always_comb begin
    mus_pkg::hold_t                                  nxt;
    mus_pkg::byte_t [mus_pkg::MAX_RES-1:0]           res;
    logic [mus_pkg::CNT_W-1:0]                       n;
    logic                                            do_start;

    nxt      = hold;
    res      = '0;
    n        = '0;
    do_start = 1'b0;

    if (hold.cnt == '0) begin
      do_start = 1'b1;
    end else if (in_byte[7:6] == mus_pkg::CONT_TAG) begin
      if (hold.three && hold.cnt == 2'd1) begin
        nxt.cont = in_byte;
        nxt.cnt  = 2'd2;
      end else begin
        // sequence complete, emit it unchanged
        res[n] = hold.lead;
        n      = n + 2'd1;
        if (hold.cnt == 2'd2) begin
          res[n] = hold.cont;
          n      = n + 2'd1;
        end
        res[n] = in_byte;
        n      = n + 2'd1;
        nxt    = '0;
      end
    end else begin
      // broken sequence: replace held bytes, then restart on this byte
      res[n] = repl;
      n      = n + 2'd1;
      if (hold.cnt == 2'd2) begin
        res[n] = repl;
        n      = n + 2'd1;
      end
      nxt      = '0;
      do_start = 1'b1;
    end

    if (do_start) begin
      if (!in_byte[7]) begin
        res[n] = in_byte;
        n      = n + 2'd1;
      end else if (in_byte[7:6] == mus_pkg::CONT_TAG ||
                   in_byte[7:4] == mus_pkg::ILLEGAL_HI) begin
        res[n] = repl;
        n      = n + 2'd1;
      end else begin
        nxt.lead  = in_byte;
        nxt.cont  = '0;
        nxt.cnt   = 2'd1;
        nxt.three = (in_byte[7:4] == mus_pkg::THREE_HI);
      end
    end

    if (string_end) begin
      if (nxt.cnt != '0) begin
        res[n] = repl;
        n      = n + 2'd1;
      end
      if (nxt.cnt == 2'd2) begin
        res[n] = repl;
        n      = n + 2'd1;
      end
      nxt = '0;
    end

    step.bytes = res;
    step.cnt   = n;
    step.hold  = nxt;
  end

endmodule

`default_nettype wire

// File: hdl/modified_utf8_byte_sanitizer_top.sv
// top level of the modified utf-8 byte sanitizer
// depends on mus_pkg, mus_skid and mus_decode
`timescale 1ns / 1ps
`default_nettype none

// Repairs a byte stream into modified UTF-8, one input beat per byte.
// ASCII passes unchanged, stray continuations and 0xF0-0xFF leads become the
// replacement byte, and two- or three-byte sequences are held until complete,
// then emitted as they came. A sequence broken by a non-continuation byte, or
// left open when tlast marks the end of the string, has each held byte
// replaced. One input byte gives zero to three output beats; the output side
// drains one beat per cycle from a three-byte result buffer while out_tready
// is high, so the block takes one byte per cycle as long as each byte gives at
// most one beat and the receiver is ready, and an input byte that gives two or
// three beats holds the input back while the buffer drains. An accepted input
// beat passes through the skid stage, then the result buffer, before its first
// output beat. The replacement byte resets to '?' and is written through
// the cfg channel, which is always ready; write it only while the stream is
// idle. Overlong forms are not checked and NUL is ordinary data.

module modified_utf8_byte_sanitizer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // string_end
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // run_last: last beat caused by one input byte
  output logic            out_tuser,  // [0] string_done
  // replacement byte register
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  // skid stage outputs
  logic                         sk_valid;
  logic                         sk_ready;
  logic [mus_pkg::IN_W-1:0]     sk_data;

  // replacement byte
  mus_pkg::byte_t               repl_r;

  // held sequence state
  mus_pkg::hold_t               hold_r;
  mus_pkg::step_t               step;

  // result buffer, beat 0 is presented
  mus_pkg::byte_t [mus_pkg::MAX_RES-1:0] obuf_r;
  logic [mus_pkg::CNT_W-1:0]    rem_r;
  logic                         end_r;

  logic                         take;
  logic                         load;

  // input skid keeps in_tready registered
  mus_skid #(
    .WIDTH (mus_pkg::IN_W)
  ) u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  ({in_tlast, in_tdata}),
    .m_valid (sk_valid),
    .m_ready (sk_ready),
    .m_data  (sk_data)
  );

  mus_decode u_decode (
    .hold       (hold_r),
    .in_byte    (sk_data[mus_pkg::BYTE_W-1:0]),
    .string_end (sk_data[mus_pkg::BYTE_W]),
    .repl       (repl_r),
    .step       (step)
  );

  // config write, always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= mus_pkg::REPL_RESET;
    end else if (cfg_valid) begin
      repl_r <= cfg_data;
    end
  end

  // result buffer handshake
  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = obuf_r[0];
  assign out_tlast  = (rem_r == 2'd1);
  assign out_tuser  = (rem_r == 2'd1) & end_r;

  assign take     = out_tvalid & out_tready;
  // new byte enters once the buffer is empty or its last beat leaves now
  assign sk_ready = (rem_r == '0) | (rem_r == 2'd1 & out_tready);
  assign load     = sk_valid & sk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      end_r  <= 1'b0;
      hold_r <= '0;
    end else if (load) begin
      rem_r  <= step.cnt;
      end_r  <= sk_data[mus_pkg::BYTE_W];
      hold_r <= step.hold;
    end else if (take) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf_r <= step.bytes;
    end else if (take) begin
      obuf_r <= {mus_pkg::byte_t'(0), obuf_r[mus_pkg::MAX_RES-1:1]};
    end
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for the modified utf-8 byte sanitizer
// depends on modified_utf8_byte_sanitizer_top and mus_pkg (through the rtl only)
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned QUIET_CYCLES = 8;      // input beat passes the skid stage and result buffer before output
  localparam logic [7:0]  REPL_AT_RESET = 8'h3F;
  localparam logic [7:0]  ASCII_TOP     = 8'h7F;
  localparam logic [7:0]  CONT_LO       = 8'h80;
  localparam logic [7:0]  CONT_HI       = 8'hBF;
  localparam logic [7:0]  LEAD2_LO      = 8'hC0;
  localparam logic [7:0]  LEAD2_HI      = 8'hDF;
  localparam logic [7:0]  LEAD3_LO      = 8'hE0;
  localparam logic [7:0]  LEAD3_HI      = 8'hEF;
  localparam logic [7:0]  ILLEGAL_LO    = 8'hF0;
  localparam logic [1:0]  CONT_TAG      = 2'b10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } repaired_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_LONG_STALL
  } sink_mode_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = '0;

  // text still to be sent, and repaired beats still to come back
  text_beat_t text_q[$];
  repaired_t  repaired_q[$];

  // predictor copy of the block state
  logic [7:0] replacement = REPL_AT_RESET;
  logic [7:0] held_lead   = '0;
  logic [7:0] held_cont   = '0;
  logic [1:0] held_count  = '0;
  logic       three_seq   = 1'b0;
  logic [7:0] step_bytes[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  sink_mode_t  sink_mode   = SINK_OPEN;

  modified_utf8_byte_sanitizer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // every held byte of a broken or unfinished sequence becomes the replacement
  task automatic drop_held();
    if (held_count >= 1) step_bytes.push_back(replacement);
    if (held_count >= 2) step_bytes.push_back(replacement);
    held_count = '0;
    held_lead  = '0;
    held_cont  = '0;
    three_seq  = 1'b0;
  endtask

  // a byte seen where a sequence would begin
  task automatic start_seq(input logic [7:0] b);
    if (b <= ASCII_TOP) begin
      step_bytes.push_back(b);
    end else if (b < LEAD2_LO || b >= ILLEGAL_LO) begin
      step_bytes.push_back(replacement);
    end else begin
      held_lead  = b;
      held_cont  = '0;
      held_count = 2'd1;
      three_seq  = (b >= LEAD3_LO);
    end
  endtask

  task automatic repair_byte(input logic [7:0] b, input logic string_end);
    repaired_t r;
    step_bytes.delete();
    if (held_count == 0) begin
      start_seq(b);
    end else if (b[7:6] == CONT_TAG) begin
      if (three_seq && held_count == 2'd1) begin
        held_cont  = b;
        held_count = 2'd2;
      end else begin
        // sequence complete, out as it came
        step_bytes.push_back(held_lead);
        if (held_count >= 2) step_bytes.push_back(held_cont);
        step_bytes.push_back(b);
        held_count = '0;
        held_lead  = '0;
        held_cont  = '0;
        three_seq  = 1'b0;
      end
    end else begin
      // broken sequence, then the breaking byte starts afresh
      drop_held();
      start_seq(b);
    end
    if (string_end) drop_held();
    foreach (step_bytes[i]) begin
      r.out_byte    = step_bytes[i];
      r.run_last    = (i == step_bytes.size() - 1);
      r.string_done = r.run_last && string_end;
      repaired_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: bursts of random length with random gaps between them
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : text_driver
    text_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) repair_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (text_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          nxt = text_q.pop_front();
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left = burst_left - 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stall pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : repaired_monitor
    repaired_t exp_beat;
    logic      rdy;
    if (rst_n && out_tvalid && out_tready) begin
      if (repaired_q.size() == 0) begin
        $display("%0t: beat with nothing expected, got byte %02h last %b done %b",
                 $time, out_tdata, out_tlast, out_tuser);
        mismatches++;
      end else begin
        exp_beat = repaired_q.pop_front();
        if (out_tdata !== exp_beat.out_byte) begin
          $display("%0t: out_byte expected %02h got %02h", $time, exp_beat.out_byte, out_tdata);
          mismatches++;
        end
        if (out_tlast !== exp_beat.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, exp_beat.run_last, out_tlast);
          mismatches++;
        end
        if (out_tuser !== exp_beat.string_done) begin
          $display("%0t: string_done expected %b got %b",
                   $time, exp_beat.string_done, out_tuser);
          mismatches++;
        end
      end
    end

    // the receiver picks a new stall style whenever the current one runs out
    if (stall_left == 0) begin
      sink_mode  = sink_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left = stall_left - 1;
    end
    case (sink_mode)
      SINK_OPEN: begin
        rdy = 1'b1;
      end
      SINK_RANDOM: begin
        rdy = ($urandom_range(0, 2) != 0);
      end
      SINK_PERIODIC: begin
        rdy = ((cycle_count % 4) != 3);
      end
      default: begin
        if (hold_left != 0) begin
          hold_left = hold_left - 1;
          rdy = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          hold_left = $urandom_range(2, 8);
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    out_tready <= rdy;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_beat(input logic [7:0] b, input logic last);
    text_beat_t t;
    t.data = b;
    t.last = last;
    text_q.push_back(t);
  endtask

  // wait until the block has nothing left in flight; checked at the falling
  // edge so the driver's queue and valid have settled
  task automatic wait_quiet();
    while (text_q.size() != 0 || in_tvalid || repaired_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_replacement(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    replacement = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed text with random content, some truncated sequences and
  // raw noise; the phase always closes a string on its final byte
  task automatic queue_text(input int unsigned n_beats);
    logic [7:0]  tok[3];
    int unsigned tok_len;
    int unsigned pick;
    int unsigned sent;
    logic        last;
    sent = 0;
    while (sent < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        tok[0]  = 8'($urandom_range(0, ASCII_TOP));
        tok_len = 1;
      end else if (pick < 65) begin
        tok[0]  = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
        tok[1]  = 8'($urandom_range(CONT_LO, CONT_HI));
        tok_len = 2;
      end else if (pick < 80) begin
        tok[0]  = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
        tok[1]  = 8'($urandom_range(CONT_LO, CONT_HI));
        tok[2]  = 8'($urandom_range(CONT_LO, CONT_HI));
        tok_len = 3;
      end else if (pick < 88) begin
        // unfinished sequence, broken by whatever follows or by the string end
        tok[0]  = 8'($urandom_range(LEAD2_LO, LEAD3_HI));
        tok[1]  = 8'($urandom_range(CONT_LO, CONT_HI));
        tok_len = (tok[0] >= LEAD3_LO) ? $urandom_range(1, 2) : 1;
      end else begin
        tok[0]  = 8'($urandom_range(0, 255));
        tok_len = 1;
      end
      last = ($urandom_range(0, 5) == 0);
      for (int unsigned i = 0; i < tok_len; i++) begin
        sent++;
        push_beat(tok[i], (i == tok_len - 1 && last) || sent == n_beats);
        if (sent == n_beats) break;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed text at the reset replacement byte
    push_beat(8'h00, 1'b0);             // nul is plain data
    push_beat(ASCII_TOP, 1'b1);
    push_beat(CONT_LO, 1'b0);           // stray continuations
    push_beat(CONT_HI, 1'b0);
    push_beat(ILLEGAL_LO, 1'b0);        // never-valid leads
    push_beat(8'hFF, 1'b0);
    push_beat(8'hC3, 1'b0);             // two-byte form, lead held with no beat
    push_beat(8'hA9, 1'b0);
    push_beat(LEAD3_HI, 1'b0);          // three-byte form at the top
    push_beat(8'hBF, 1'b0);
    push_beat(8'hBF, 1'b0);
    push_beat(8'hC3, 1'b0);             // two-byte form broken by ascii
    push_beat(8'h41, 1'b0);
    push_beat(8'hE2, 1'b0);             // three-byte form broken after a continuation
    push_beat(8'h82, 1'b0);
    push_beat(8'h41, 1'b0);
    push_beat(LEAD2_LO, 1'b0);          // lead broken by another lead, which then completes
    push_beat(LEAD2_HI, 1'b0);
    push_beat(CONT_LO, 1'b0);
    push_beat(LEAD3_LO, 1'b1);          // lone lead flushed by the string end
    push_beat(8'hE2, 1'b0);             // break plus flush: three beats from one byte
    push_beat(8'h82, 1'b0);
    push_beat(8'hC3, 1'b1);
    wait_quiet();

    write_replacement(8'h00);
    queue_text(95);
    wait_quiet();

    write_replacement(8'hFF);
    queue_text(95);
    // hold the sender until every repaired beat is back, then carry on
    wait_quiet();
    queue_text(45);
    wait_quiet();

    write_replacement(8'($urandom_range(0, 255)));
    queue_text(75);
    wait_quiet();

    write_replacement(REPL_AT_RESET);
    queue_text(75);
    wait_quiet();

    if (repaired_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, repaired_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
